/* rtl/irsq_pkg.sv */
// shared constants, types and width helpers for the r-squared accumulator
package irsq_pkg;

  localparam int SAMPLE_COUNT_BITS_DEF = 20;
  localparam int PROB_FRAC_BITS_DEF    = 15;

  localparam int PROB_W        = 16;
  localparam int RSQ_W         = 18;
  localparam int STATUS_W      = 2;
  localparam int OUT_FRAC_BITS = 16;
  // quotient bits produced by the divider: two integer bits plus the fraction
  localparam int QUOT_BITS     = OUT_FRAC_BITS + 2;

  localparam logic [RSQ_W-1:0] RSQ_ONE = RSQ_W'(1 << OUT_FRAC_BITS);
  localparam logic [RSQ_W-1:0] RSQ_MAX = RSQ_W'(2 << OUT_FRAC_BITS);

  typedef enum logic [STATUS_W-1:0] {
    ST_COMPUTED     = 2'd0,
    ST_MONOMORPHIC  = 2'd1,
    ST_NO_MASS      = 2'd2,
    ST_INCONSISTENT = 2'd3
  } rsq_status_t;

  typedef enum logic [1:0] {
    MUL_SQ = 2'd0,
    MUL_NT = 2'd1,
    MUL_DV = 2'd2
  } mul_op_t;

  typedef struct packed {
    logic    take;
    logic    classify;
    logic    mul_load;
    mul_op_t mul_op;
    logic    mul_step;
    logic    mul_store;
    logic    cmp;
    logic    chk;
    logic    div_step;
    logic    div_fin;
    logic    publish;
  } irsq_cmd_t;

  typedef struct packed {
    logic special;
    logic neg;
    logic over;
  } irsq_sts_t;

  function automatic int sum_width(int scb, int pfb);
    return scb + pfb + 2;
  endfunction

  function automatic int sq_width(int scb, int pfb);
    int raw;
    raw = scb + 2 * pfb + 4;
    return (raw > 64) ? 64 : raw;
  endfunction

  // widest multiplier operand: the square sum or 2N - T2
  function automatic int mulb_width(int scb, int pfb);
    int a;
    int b;
    a = sq_width(scb, pfb);
    b = sum_width(scb, pfb) + 1;
    return (a > b) ? a : b;
  endfunction

endpackage

/* rtl/irsq_if.sv */
// sample and result channel interfaces
interface irsq_in_if;
  import irsq_pkg::*;

  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] prob_hom_ref;
  logic [PROB_W-1:0] prob_het;
  logic [PROB_W-1:0] prob_hom_alt;
  logic              last_sample;

  modport source (output valid, prob_hom_ref, prob_het, prob_hom_alt, last_sample,
                  input ready);
  modport sink   (input valid, prob_hom_ref, prob_het, prob_hom_alt, last_sample,
                  output ready);
endinterface

interface irsq_out_if;
  import irsq_pkg::*;

  logic                valid;
  logic                ready;
  logic [RSQ_W-1:0]    rsq_value;
  logic [STATUS_W-1:0] rsq_status;

  modport source (output valid, rsq_value, rsq_status, input ready);
  modport sink   (input valid, rsq_value, rsq_status, output ready);
endinterface

/* rtl/irsq_datapath.sv */
// accumulators, shift-add multiplier, restoring divider and result registers
module irsq_datapath #(
  parameter int SAMPLE_COUNT_BITS = irsq_pkg::SAMPLE_COUNT_BITS_DEF,
  parameter int PROB_FRAC_BITS    = irsq_pkg::PROB_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irsq_pkg::irsq_cmd_t           cmd,
  output irsq_pkg::irsq_sts_t           sts,
  input  logic [irsq_pkg::PROB_W-1:0]   prob_hom_ref,
  input  logic [irsq_pkg::PROB_W-1:0]   prob_het,
  input  logic [irsq_pkg::PROB_W-1:0]   prob_hom_alt,
  output logic [irsq_pkg::RSQ_W-1:0]    rsq_value,
  output logic [irsq_pkg::STATUS_W-1:0] rsq_status
);
  import irsq_pkg::*;

  localparam int SUM_W  = sum_width(SAMPLE_COUNT_BITS, PROB_FRAC_BITS);
  localparam int SQ_W   = sq_width(SAMPLE_COUNT_BITS, PROB_FRAC_BITS);
  localparam int MULB_W = mulb_width(SAMPLE_COUNT_BITS, PROB_FRAC_BITS);
  localparam int PROD_W = SUM_W + MULB_W;
  localparam int DOS_W  = PROB_W + 2;
  localparam int DSQ_W  = 2 * DOS_W;
  localparam int REM_W  = PROD_W + PROB_FRAC_BITS + QUOT_BITS;

  // input stage
  logic             s1_valid_r;
  logic [DOS_W-1:0] s1_mass_r;
  logic [DOS_W-1:0] s1_dos_r;
  logic [DSQ_W-1:0] s1_dsq_r;
  logic [DOS_W-1:0] dos_in;
  logic [DSQ_W-1:0] dsq_in;

  // row accumulators
  logic [SUM_W-1:0] mass_r;
  logic [SUM_W-1:0] dos_r;
  logic [SQ_W-1:0]  dsq_r;

  // multiplier
  logic [PROD_W-1:0] mul_a_r;
  logic [MULB_W-1:0] mul_b_r;
  logic [PROD_W-1:0] mul_p_r;
  mul_op_t           mul_op_r;
  logic [PROD_W-1:0] p_sq_r;
  logic [PROD_W-1:0] p_nt_r;
  logic [PROD_W-1:0] p_div_r;
  logic [PROD_W-1:0] ld_a;
  logic [MULB_W-1:0] ld_b;

  // divider
  logic [REM_W-1:0]     rem_r;
  logic [REM_W-1:0]     div_r;
  logic [QUOT_BITS-1:0] q_r;
  logic [REM_W-1:0]     nt_ext;
  logic [REM_W-1:0]     sq_sh;
  logic                 rem_ge;

  // result
  logic [RSQ_W-1:0] res_value_r;
  rsq_status_t      res_status_r;
  logic [RSQ_W-1:0] out_value_r;
  rsq_status_t      out_status_r;

  // special case flags
  logic [SUM_W:0] two_n;
  logic [SUM_W:0] t2_ext;
  logic [SUM_W:0] two_n_less_t2;
  logic           n_zero;
  logic           t2_zero;
  logic           t2_eq;
  logic           t2_gt;

  assign dos_in = DOS_W'(prob_het) + (DOS_W'(prob_hom_alt) << 1);
  assign dsq_in = DSQ_W'(dos_in) * DSQ_W'(dos_in);

  assign two_n         = {mass_r, 1'b0};
  assign t2_ext        = {1'b0, dos_r};
  assign two_n_less_t2 = two_n - t2_ext;
  assign n_zero        = (mass_r == '0);
  assign t2_zero       = (dos_r == '0);
  assign t2_eq         = (t2_ext == two_n);
  assign t2_gt         = (t2_ext > two_n);

  assign nt_ext = REM_W'(p_nt_r);
  assign sq_sh  = REM_W'(p_sq_r) << PROB_FRAC_BITS;
  assign rem_ge = (rem_r >= div_r);

  assign sts.special = n_zero | t2_zero | t2_eq | t2_gt;
  assign sts.neg     = (nt_ext < sq_sh);
  assign sts.over    = (rem_r >= {div_r[REM_W-2:0], 1'b0});

  always_comb begin
    ld_a = '0;
    ld_b = '0;
    case (cmd.mul_op)
      MUL_SQ: begin
        ld_a = PROD_W'(dos_r);
        ld_b = MULB_W'(dos_r);
      end
      MUL_NT: begin
        ld_a = PROD_W'(mass_r);
        ld_b = MULB_W'(dsq_r);
      end
      MUL_DV: begin
        ld_a = PROD_W'(dos_r);
        ld_b = MULB_W'(two_n_less_t2);
      end
      default: begin
        ld_a = '0;
        ld_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.take;
    end
    if (cmd.take) begin
      s1_mass_r <= DOS_W'(prob_hom_ref) + DOS_W'(prob_het) + DOS_W'(prob_hom_alt);
      s1_dos_r  <= dos_in;
      s1_dsq_r  <= dsq_in;
    end
  end

  // sums wrap at their width
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.publish) begin
      mass_r <= '0;
      dos_r  <= '0;
      dsq_r  <= '0;
    end else if (s1_valid_r) begin
      mass_r <= SUM_W'(mass_r + SUM_W'(s1_mass_r));
      dos_r  <= SUM_W'(dos_r + SUM_W'(s1_dos_r));
      dsq_r  <= SQ_W'(dsq_r + SQ_W'(s1_dsq_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_store) begin
      case (mul_op_r)
        MUL_SQ:  p_sq_r  <= mul_p_r;
        MUL_NT:  p_nt_r  <= mul_p_r;
        MUL_DV:  p_div_r <= mul_p_r;
        default: p_div_r <= mul_p_r;
      endcase
    end
    if (cmd.mul_load) begin
      mul_a_r  <= ld_a;
      mul_b_r  <= ld_b;
      mul_p_r  <= '0;
      mul_op_r <= cmd.mul_op;
    end else if (cmd.mul_step) begin
      if (mul_b_r[0]) begin
        mul_p_r <= mul_p_r + mul_a_r;
      end
      mul_a_r <= mul_a_r << 1;
      mul_b_r <= mul_b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      // numerator and divisor aligned for the top quotient bit
      rem_r <= (nt_ext - sq_sh) << (QUOT_BITS - 1);
      div_r <= REM_W'(p_div_r) << (PROB_FRAC_BITS + QUOT_BITS - 1);
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= rem_r - div_r;
      end
      div_r <= div_r >> 1;
      q_r   <= {q_r[QUOT_BITS-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      if (n_zero) begin
        res_value_r  <= t2_zero ? RSQ_ONE : '0;
        res_status_r <= ST_NO_MASS;
      end else if (t2_zero || t2_eq) begin
        res_value_r  <= RSQ_ONE;
        res_status_r <= ST_MONOMORPHIC;
      end else begin
        res_value_r  <= '0;
        res_status_r <= t2_gt ? ST_INCONSISTENT : ST_COMPUTED;
      end
    end else if (cmd.chk) begin
      res_value_r  <= sts.over ? RSQ_MAX : '0;
      res_status_r <= ST_COMPUTED;
    end else if (cmd.div_fin) begin
      res_value_r  <= (q_r > RSQ_MAX) ? RSQ_MAX : q_r;
      res_status_r <= ST_COMPUTED;
    end
    if (cmd.publish) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign rsq_value  = out_value_r;
  assign rsq_status = out_status_r;

endmodule

/* rtl/irsq_ctrl.sv */
// sequencer: sample intake, product sequence, divide steps and result handoff
module irsq_ctrl #(
  parameter int SAMPLE_COUNT_BITS = irsq_pkg::SAMPLE_COUNT_BITS_DEF,
  parameter int PROB_FRAC_BITS    = irsq_pkg::PROB_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output irsq_pkg::irsq_cmd_t cmd,
  input  irsq_pkg::irsq_sts_t sts
);
  import irsq_pkg::*;

  localparam int MULB_W = mulb_width(SAMPLE_COUNT_BITS, PROB_FRAC_BITS);
  localparam int CNT_MAX = (MULB_W > QUOT_BITS) ? MULB_W : QUOT_BITS;
  localparam int CNT_W  = $clog2(CNT_MAX);

  typedef enum logic [3:0] {
    S_ACC,
    S_DRAIN,
    S_CLASS,
    S_MUL,
    S_MSTORE,
    S_CMP,
    S_CHK,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  mul_op_t          op_r;
  mul_op_t          op_next;
  logic             out_valid_r;
  logic             take;
  logic             out_free;

  assign in_ready  = (state_r == S_ACC);
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    case (op_r)
      MUL_SQ:  op_next = MUL_NT;
      MUL_NT:  op_next = MUL_DV;
      default: op_next = MUL_DV;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_ACC: cmd.take = take;
      S_CLASS: begin
        cmd.classify = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_op   = MUL_SQ;
      end
      S_MUL: cmd.mul_step = 1'b1;
      S_MSTORE: begin
        cmd.mul_store = 1'b1;
        cmd.mul_load  = (op_r != MUL_DV);
        cmd.mul_op    = op_next;
      end
      S_CMP:   cmd.cmp      = 1'b1;
      S_CHK:   cmd.chk      = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_FIN:   cmd.div_fin  = 1'b1;
      S_DONE:  cmd.publish  = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      cnt_r       <= '0;
      op_r        <= MUL_SQ;
      out_valid_r <= 1'b0;
    end else begin
      // a new result loads, a held one stays until taken
      out_valid_r <= (state_r == S_DONE && out_free) || (out_valid_r && !out_ready);
      case (state_r)
        S_ACC: begin
          if (take && in_last) begin
            state_r <= S_DRAIN;
          end
        end
        // last sample lands in the accumulators
        S_DRAIN: state_r <= S_CLASS;
        S_CLASS: begin
          cnt_r <= '0;
          op_r  <= MUL_SQ;
          state_r <= sts.special ? S_DONE : S_MUL;
        end
        S_MUL: begin
          if (cnt_r == CNT_W'(MULB_W - 1)) begin
            state_r <= S_MSTORE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_MSTORE: begin
          cnt_r <= '0;
          if (op_r == MUL_DV) begin
            state_r <= S_CMP;
          end else begin
            op_r    <= op_next;
            state_r <= S_MUL;
          end
        end
        S_CMP: state_r <= sts.neg ? S_DONE : S_CHK;
        S_CHK: begin
          cnt_r   <= '0;
          state_r <= sts.over ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (cnt_r == CNT_W'(QUOT_BITS - 1)) begin
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_FIN: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_r <= S_ACC;
          end
        end
        default: state_r <= S_ACC;
      endcase
    end
  end

endmodule

/* rtl/imputation_rsquared_accumulator.sv */
// top level: r-squared imputation quality of one row of genotype probabilities
// Samples are taken one per cycle while a row accumulates.
// After the last_sample request intake stops until the result reaches the output register;
// special rows skip the arithmetic, others run three shift-add products over the widest
// product operand (54 bits by default) and an 18-step restoring divider; negative variance
// ends after the products, a ratio above 2.0 before the divider; a held result adds stall.
// Synchronous active-low reset clears the accumulators, the sequencer and the output valid.
module imputation_rsquared_accumulator #(
  parameter int SAMPLE_COUNT_BITS = irsq_pkg::SAMPLE_COUNT_BITS_DEF,
  parameter int PROB_FRAC_BITS    = irsq_pkg::PROB_FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  irsq_in_if.sink    in_chan,
  irsq_out_if.source out_chan
);
  import irsq_pkg::*;

  irsq_cmd_t cmd;
  irsq_sts_t sts;

  irsq_ctrl #(
    .SAMPLE_COUNT_BITS (SAMPLE_COUNT_BITS),
    .PROB_FRAC_BITS    (PROB_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_last   (in_chan.last_sample),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  irsq_datapath #(
    .SAMPLE_COUNT_BITS (SAMPLE_COUNT_BITS),
    .PROB_FRAC_BITS    (PROB_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .prob_hom_ref (in_chan.prob_hom_ref),
    .prob_het     (in_chan.prob_het),
    .prob_hom_alt (in_chan.prob_hom_alt),
    .rsq_value    (out_chan.rsq_value),
    .rsq_status   (out_chan.rsq_status)
  );

endmodule

/* rtl/irsq_checker.sv */
// port-level checks for the r-squared accumulator and their binding
module irsq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [irsq_pkg::RSQ_W-1:0]    rsq_value,
  input logic [irsq_pkg::STATUS_W-1:0] rsq_status
);
  import irsq_pkg::*;

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // intake closes once a row has ended
  a_row_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("request taken after the last sample of a row");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> rsq_value <= RSQ_MAX)
    else $error("r-squared above 2.0");

  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rsq_status == ST_MONOMORPHIC |-> rsq_value == RSQ_ONE)
    else $error("monomorphic row without value one");

  a_incons: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rsq_status == ST_INCONSISTENT |-> rsq_value == '0)
    else $error("inconsistent dosage row with nonzero value");

endmodule

bind imputation_rsquared_accumulator irsq_checker u_irsq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_last    (in_chan.last_sample),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .rsq_value  (out_chan.rsq_value),
  .rsq_status (out_chan.rsq_status)
);

/* bench/imputation_rsquared_accumulator_test.sv */
// self-checking testbench for the r-squared accumulator: directed, random and long rows
module imputation_rsquared_accumulator_test;
  import irsq_pkg::*;

  localparam int SCB = SAMPLE_COUNT_BITS_DEF;
  localparam int PFB = PROB_FRAC_BITS_DEF;
  localparam int SUM_W = SCB + PFB + 2;
  localparam int SQ_W = (SCB + 2 * PFB + 4 > 64) ? 64 : SCB + 2 * PFB + 4;
  localparam int WIDE = 160;
  localparam int RANDOM_SAMPLES = 1500;
  localparam int DRAIN_CYCLES = 250;
  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1 << PFB);
  localparam logic [PROB_W-1:0] PROB_FULL = '1;

  typedef struct packed {
    logic [RSQ_W-1:0] value;
    rsq_status_t      status;
  } rsq_result_t;

  logic clk = 1'b0;
  logic rst_n;

  irsq_in_if  in_if ();
  irsq_out_if out_if ();

  imputation_rsquared_accumulator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // row accumulators of the predictor
  logic [SUM_W-1:0] mass_acc;
  logic [SUM_W-1:0] dosage_acc;
  logic [SQ_W-1:0]  square_acc;

  rsq_result_t expected_rsq_q[$];
  rsq_result_t expected_now;
  int          failures = 0;
  bit          idle_on = 1'b1;
  int          ready_hold = 0;
  bit          r_mono_alt;

  function automatic int idle_cycles();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // floor(2^17 * (N*T1 - 2^F*T2^2) / (2^F * T2 * (2N - T2))), clamped to 2.0
  function automatic logic [RSQ_W-1:0] predict_rsq(input logic [SUM_W-1:0] n,
                                                   input logic [SUM_W-1:0] t2,
                                                   input logic [SQ_W-1:0] t1);
    logic [WIDE-1:0] wn;
    logic [WIDE-1:0] wt2;
    logic [WIDE-1:0] wt1;
    logic [WIDE-1:0] num;
    logic [WIDE-1:0] var_term;
    logic [WIDE-1:0] den;
    logic [WIDE-1:0] quot;
    wn = WIDE'(n);
    wt2 = WIDE'(t2);
    wt1 = WIDE'(t1);
    num = (wn * wt1) << (OUT_FRAC_BITS + 1);
    var_term = (wt2 * wt2) << (OUT_FRAC_BITS + 1 + PFB);
    if (num < var_term) return '0;
    num = num - var_term;
    den = (wt2 * ((wn << 1) - wt2)) << PFB;
    if (num >= (den << QUOT_BITS)) return RSQ_MAX;
    quot = num / den;
    if (quot > WIDE'(RSQ_MAX)) return RSQ_MAX;
    return quot[RSQ_W-1:0];
  endfunction

  task automatic accumulate_sample(input logic [PROB_W-1:0] aa, input logic [PROB_W-1:0] ab,
                                   input logic [PROB_W-1:0] bb, input logic last_one);
    logic [17:0]      dosage;
    logic [35:0]      dosage_wide;
    logic [35:0]      dosage_sq;
    logic [SUM_W:0]   two_n;
    logic [SUM_W:0]   t2_ext;
    rsq_result_t      res;
    dosage = {2'b00, ab} + {1'b0, bb, 1'b0};
    dosage_wide = 36'(dosage);
    dosage_sq = dosage_wide * dosage_wide;
    mass_acc = mass_acc + SUM_W'(aa) + SUM_W'(ab) + SUM_W'(bb);
    dosage_acc = dosage_acc + SUM_W'(dosage);
    square_acc = square_acc + SQ_W'(dosage_sq);
    if (last_one) begin
      two_n = {mass_acc, 1'b0};
      t2_ext = {1'b0, dosage_acc};
      if (mass_acc == '0) begin
        res.value = (dosage_acc == '0) ? RSQ_ONE : '0;
        res.status = ST_NO_MASS;
      end else if (dosage_acc == '0 || t2_ext == two_n) begin
        res.value = RSQ_ONE;
        res.status = ST_MONOMORPHIC;
      end else if (t2_ext > two_n) begin
        res.value = '0;
        res.status = ST_INCONSISTENT;
      end else begin
        res.value = predict_rsq(mass_acc, dosage_acc, square_acc);
        res.status = ST_COMPUTED;
      end
      expected_rsq_q.push_back(res);
      mass_acc = '0;
      dosage_acc = '0;
      square_acc = '0;
    end
  endtask

  task automatic send_sample(input logic [PROB_W-1:0] aa, input logic [PROB_W-1:0] ab,
                             input logic [PROB_W-1:0] bb, input logic last_one);
    int gap;
    in_if.valid <= 1'b1;
    in_if.prob_hom_ref <= aa;
    in_if.prob_het <= ab;
    in_if.prob_hom_alt <= bb;
    in_if.last_sample <= last_one;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    accumulate_sample(aa, ab, bb, last_one);
    gap = idle_cycles();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one sample drawn from the given row flavor
  task automatic draw_sample(input int row_kind, output logic [PROB_W-1:0] aa,
                             output logic [PROB_W-1:0] ab, output logic [PROB_W-1:0] bb);
    int p;
    int q;
    int r;
    int rot;
    if (row_kind == 3 || (row_kind == 0 && $urandom_range(0, 19) == 0)) begin
      aa = PROB_W'($urandom);
      ab = PROB_W'($urandom);
      bb = PROB_W'($urandom);
    end else if (row_kind == 2) begin
      aa = (r_mono_alt) ? '0 : PROB_ONE;
      ab = '0;
      bb = (r_mono_alt) ? PROB_ONE : '0;
    end else begin
      if (row_kind == 1) begin
        p = int'(PROB_ONE);
        q = 0;
      end else begin
        p = $urandom_range(0, int'(PROB_ONE));
        q = $urandom_range(0, int'(PROB_ONE) - p);
      end
      r = int'(PROB_ONE) - p - q;
      rot = $urandom_range(0, 2);
      case (rot)
        0: begin aa = PROB_W'(p); ab = PROB_W'(q); bb = PROB_W'(r); end
        1: begin aa = PROB_W'(r); ab = PROB_W'(p); bb = PROB_W'(q); end
        default: begin aa = PROB_W'(q); ab = PROB_W'(r); bb = PROB_W'(p); end
      endcase
    end
  endtask

  task automatic test_directed_rows();
    idle_on = 1'b1;
    send_sample('0, '0, '0, 1'b1);
    send_sample(PROB_ONE, '0, '0, 1'b1);
    send_sample('0, '0, PROB_ONE, 1'b1);
    // mass below one with all dosage on the het call gives negative variance
    send_sample('0, PROB_ONE >> 1, '0, 1'b1);
    // ratio far above two
    send_sample(PROB_FULL, '0, PROB_FULL, 1'b1);
    send_sample(PROB_FULL, PROB_FULL, PROB_FULL, 1'b1);
    send_sample(PROB_ONE >> 1, PROB_ONE >> 1, '0, 1'b0);
    send_sample('0, PROB_ONE, '0, 1'b0);
    send_sample(PROB_ONE >> 2, PROB_ONE >> 2, PROB_ONE >> 1, 1'b1);
    send_sample(PROB_ONE, '0, '0, 1'b0);
    send_sample('0, PROB_ONE, '0, 1'b0);
    send_sample('0, '0, PROB_ONE, 1'b1);
    send_sample('0, '0, PROB_FULL, 1'b0);
    send_sample('0, '0, PROB_FULL, 1'b1);
    send_sample(16'd1, '0, '0, 1'b0);
    send_sample('0, 16'd1, '0, 1'b1);
  endtask

  task automatic test_random_rows();
    int sent;
    int len;
    int r;
    int row_kind;
    logic [PROB_W-1:0] aa;
    logic [PROB_W-1:0] ab;
    logic [PROB_W-1:0] bb;
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 6);
      else if (r < 98) len = $urandom_range(7, 30);
      else len = $urandom_range(31, 120);
      r = $urandom_range(0, 99);
      if (r < 60) row_kind = 0;
      else if (r < 75) row_kind = 1;
      else if (r < 85) row_kind = 2;
      else row_kind = 3;
      r_mono_alt = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
        draw_sample(row_kind, aa, ab, bb);
        send_sample(aa, ab, bb, i == len - 1);
      end
      sent += len;
    end
  endtask

  // one long row back to back: full-scale samples, then mass without dosage
  task automatic test_long_row();
    idle_on = 1'b0;
    repeat (100) send_sample(PROB_FULL, PROB_FULL, PROB_FULL, 1'b0);
    repeat (29) send_sample(PROB_FULL, '0, '0, 1'b0);
    send_sample(PROB_FULL, '0, '0, 1'b1);
    idle_on = 1'b1;
  endtask

  // result side backpressure
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (ready_hold > 0) begin
        out_if.ready <= 1'b0;
        ready_hold--;
      end else begin
        out_if.ready <= 1'b1;
        ready_hold = idle_cycles();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_rsq_q.size() == 0) begin
        $error("unexpected result: rsq_value %0d rsq_status %0d",
               out_if.rsq_value, out_if.rsq_status);
        failures++;
      end else begin
        expected_now = expected_rsq_q.pop_front();
        if (out_if.rsq_value !== expected_now.value) begin
          $error("rsq_value mismatch: expected %0d, actual %0d",
                 expected_now.value, out_if.rsq_value);
          failures++;
        end
        if (out_if.rsq_status !== expected_now.status) begin
          $error("rsq_status mismatch: expected %0d, actual %0d",
                 expected_now.status, out_if.rsq_status);
          failures++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.prob_hom_ref <= '0;
    in_if.prob_het <= '0;
    in_if.prob_hom_alt <= '0;
    in_if.last_sample <= 1'b0;
    mass_acc = '0;
    dosage_acc = '0;
    square_acc = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_rows();
    test_random_rows();
    test_long_row();
    in_if.valid <= 1'b0;
    while (expected_rsq_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
